### sv/fed_pkg.sv
`timescale 1ns / 1ps

package fed_pkg;

	localparam int MAX_SIDE_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port
	localparam int CFG_W = 11;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH_A  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT_A = 2'd1;
	localparam logic [IDX_W-1:0] REG_WIDTH_B  = 2'd2;
	localparam logic [IDX_W-1:0] REG_HEIGHT_B = 2'd3;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1;

	// accumulator and root
	localparam int SUM_W      = 52;
	localparam int DIST_W     = 26;
	localparam int ROOT_STEPS = SUM_W / 2;

	typedef struct packed {
		logic take;
	} dp_cmd_t;

	typedef struct packed {
		logic last_item;
		logic root_done;
	} dp_status_t;

endpackage

### sv/fed_isqrt.sv
`timescale 1ns / 1ps

module fed_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fed_pkg::SUM_W-1:0]    operand,
	output logic [fed_pkg::DIST_W-1:0]   root,
	output logic                         done
);

	localparam int SUM_W  = fed_pkg::SUM_W;
	localparam int DIST_W = fed_pkg::DIST_W;
	localparam int STEP_W = $clog2(fed_pkg::ROOT_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(fed_pkg::ROOT_STEPS - 1);

	logic [SUM_W-1:0]  op_q;
	logic [DIST_W:0]   rem_q;
	logic [DIST_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DIST_W+2:0] rem_sh;
	logic [DIST_W+2:0] trial;
	logic [DIST_W+2:0] rem_sub;
	logic              fits;

	// one result bit per cycle, two operand bits brought down each time
	always_comb begin
		rem_sh  = {rem_q, op_q[SUM_W-1:SUM_W-2]};
		trial   = {1'b0, root_q, 2'b01};
		fits    = rem_sh >= trial;
		rem_sub = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q   <= {op_q[SUM_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[DIST_W:0] : rem_sh[DIST_W:0];
			root_q <= {root_q[DIST_W-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

### sv/fed_datapath.sv
`timescale 1ns / 1ps

module fed_datapath #(
	parameter int MAX_SIDE    = fed_pkg::MAX_SIDE_DEF,
	parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [fed_pkg::IDX_W-1:0]           wr_index,
	input  logic [fed_pkg::CFG_W-1:0]           wr_data,
	input  logic signed [SAMPLE_BITS-1:0]       sample_a,
	input  logic signed [SAMPLE_BITS-1:0]       sample_b,
	input  fed_pkg::dp_cmd_t                    cmd,
	output fed_pkg::dp_status_t                 status,
	output logic [fed_pkg::DIST_W-1:0]          distance,
	output logic                                mismatch
);

	localparam int CFG_W  = fed_pkg::CFG_W;
	localparam int SUM_W  = fed_pkg::SUM_W;
	localparam int DIST_W = fed_pkg::DIST_W;
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int TOT_W  = 2 * SIDE_W;
	localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
	localparam int SQ_W   = 2 * SAMPLE_BITS;

	logic [CFG_W-1:0] width_a_q;
	logic [CFG_W-1:0] height_a_q;
	logic [CFG_W-1:0] width_b_q;
	logic [CFG_W-1:0] height_b_q;

	logic [SIDE_W-1:0] side_w;
	logic [SIDE_W-1:0] side_h;
	logic [TOT_W-1:0]  total;
	logic [TOT_W:0]    cnt_inc;
	logic [TOT_W-1:0]  cnt_q;
	logic              last_item;
	logic              mism;

	logic [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS:0]   mag_full;

	logic                   v_s1, last_s1, mism_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   v_s2, last_s2, mism_s2;
	logic [SQ_W-1:0]        sq_s2;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] add_val;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;
	logic             mism_f_q;
	logic             root_start;
	logic [DIST_W-1:0] root;
	logic             root_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_a_q  <= fed_pkg::CFG_RESET;
			height_a_q <= fed_pkg::CFG_RESET;
			width_b_q  <= fed_pkg::CFG_RESET;
			height_b_q <= fed_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				fed_pkg::REG_WIDTH_A:  width_a_q  <= wr_data;
				fed_pkg::REG_HEIGHT_A: height_a_q <= wr_data;
				fed_pkg::REG_WIDTH_B:  width_b_q  <= wr_data;
				fed_pkg::REG_HEIGHT_B: height_b_q <= wr_data;
				default: ;
			endcase
		end
	end

	// frame size from frame a, sides clamped; a zero side makes every item last
	always_comb begin
		side_w = (CMP_W'(width_a_q) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
			: SIDE_W'(width_a_q);
		side_h = (CMP_W'(height_a_q) > CMP_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
			: SIDE_W'(height_a_q);
		total     = TOT_W'(side_w) * TOT_W'(side_h);
		cnt_inc   = {1'b0, cnt_q} + 1'b1;
		last_item = cnt_inc >= {1'b0, total};
		mism      = (width_a_q != width_b_q) || (height_a_q != height_b_q);
		diff      = {sample_a[SAMPLE_BITS-1], sample_a} - {sample_b[SAMPLE_BITS-1], sample_b};
		mag_full  = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			mism_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			mism_s2 <= 1'b0;
			sum_q   <= '0;
			mism_f_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				cnt_q <= last_item ? '0 : cnt_inc[TOT_W-1:0];
			end
			v_s1    <= cmd.take;
			last_s1 <= last_item;
			mism_s1 <= mism;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			mism_s2 <= mism_s1;
			if (v_s2) begin
				sum_q <= last_s2 ? '0 : sum_next;
			end
			if (root_start) begin
				mism_f_q <= mism_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_full[SAMPLE_BITS-1:0];
		sq_s2  <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
	end

	// saturating accumulate, samples of mismatched frames add nothing
	always_comb begin
		add_val    = mism_s2 ? '0 : SUM_W'(sq_s2);
		sum_wide   = {1'b0, sum_q} + {1'b0, add_val};
		sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		root_start = v_s2 && last_s2;
	end

	fed_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (sum_next),
		.root    (root),
		.done    (root_done)
	);

	assign status.last_item = last_item;
	assign status.root_done = root_done;
	assign distance = mism_f_q ? '0 : root;
	assign mismatch = mism_f_q;

endmodule

### sv/fed_ctrl.sv
`timescale 1ns / 1ps

module fed_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output fed_pkg::dp_cmd_t     cmd,
	input  fed_pkg::dp_status_t  status
);

	localparam logic [1:0] ST_ACCUM = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_OUT   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (sample_valid && status.last_item) state_next = ST_BUSY;
			end
			ST_BUSY: begin
				if (status.root_done) state_next = ST_OUT;
			end
			ST_OUT: begin
				if (!result_stall) state_next = ST_ACCUM;
			end
			default: state_next = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_next;
		end
	end

	assign sample_stall = state_q != ST_ACCUM;
	assign result_valid = state_q == ST_OUT;
	assign cmd.take     = (state_q == ST_ACCUM) && sample_valid;

endmodule

### sv/frame_euclidean_distance_unit.sv
// result: valid once the last item of a frame has left the square stages and the bit-serial root has finished
// throughput: one item per cycle within a frame, set by the two-stage square pipeline
// between frames the input stalls while the bit-serial root (26 steps) runs and until the result is taken
// reset: asynchronous, active low; frame sizes return to 1, sum and item count cleared
`timescale 1ns / 1ps

module frame_euclidean_distance_unit #(
	parameter int MAX_SIDE    = fed_pkg::MAX_SIDE_DEF,
	parameter int SAMPLE_BITS = fed_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [fed_pkg::IDX_W-1:0]      wr_index,
	input  logic [fed_pkg::CFG_W-1:0]      wr_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample_a,
	input  logic signed [SAMPLE_BITS-1:0]  sample_b,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [fed_pkg::DIST_W-1:0]     distance,
	output logic                           mismatch
);

	fed_pkg::dp_cmd_t    cmd;
	fed_pkg::dp_status_t status;

	fed_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

	fed_datapath #(
		.MAX_SIDE    (MAX_SIDE),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.cmd      (cmd),
		.status   (status),
		.distance (distance),
		.mismatch (mismatch)
	);

`ifndef NO_ASSERTIONS
	// no item enters while a result is shown
	a_stall_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> sample_stall)
		else $error("item taken while result pending");

	// a mismatched frame reports zero distance
	a_mismatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && mismatch) |-> (distance == '0))
		else $error("nonzero distance on mismatch");

	// a result is not shown again once it has been taken
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall) |=> !result_valid)
		else $error("result repeated");
`endif

endmodule
